@@ rtl/des_pkg.sv @@
// DES package: permutation tables, S-boxes and round helper functions.
// Used by the round cell and the top level; depends on nothing.
package des_pkg;

  localparam int unsigned Rounds = 16;
  localparam int unsigned HalfKeyBits = 28;
  localparam int unsigned SubkeyBits = 48;

  localparam logic [0:63][6:0] TabIp = '{
    58,50,42,34,26,18,10,2, 60,52,44,36,28,20,12,4,
    62,54,46,38,30,22,14,6, 64,56,48,40,32,24,16,8,
    57,49,41,33,25,17,9,1,  59,51,43,35,27,19,11,3,
    61,53,45,37,29,21,13,5, 63,55,47,39,31,23,15,7};

  localparam logic [0:63][6:0] TabFp = '{
    40,8,48,16,56,24,64,32, 39,7,47,15,55,23,63,31,
    38,6,46,14,54,22,62,30, 37,5,45,13,53,21,61,29,
    36,4,44,12,52,20,60,28, 35,3,43,11,51,19,59,27,
    34,2,42,10,50,18,58,26, 33,1,41,9,49,17,57,25};

  localparam logic [0:47][5:0] TabE = '{
    32,1,2,3,4,5, 4,5,6,7,8,9, 8,9,10,11,12,13, 12,13,14,15,16,17,
    16,17,18,19,20,21, 20,21,22,23,24,25, 24,25,26,27,28,29, 28,29,30,31,32,1};

  localparam logic [0:31][5:0] TabP = '{
    16,7,20,21,29,12,28,17, 1,15,23,26,5,18,31,10,
    2,8,24,14,32,27,3,9, 19,13,30,6,22,11,4,25};

  localparam logic [0:55][6:0] TabPc1 = '{
    57,49,41,33,25,17,9,1,58,50,42,34,26,18,10,2,59,51,43,35,27,19,11,3,
    60,52,44,36,63,55,47,39,31,23,15,7,62,54,46,38,30,22,14,6,61,53,45,37,
    29,21,13,5,28,20,12,4};

  localparam logic [0:47][5:0] TabPc2 = '{
    14,17,11,24,1,5,3,28,15,6,21,10,23,19,12,4,26,8,16,7,27,20,13,2,
    41,52,31,37,47,55,30,40,51,45,33,48,44,49,39,56,34,53,46,42,50,36,29,32};

  localparam logic [0:15] TabRotTwo = 16'b0011111101111110;

  localparam logic [0:7][0:63][3:0] TabS = '{
    '{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7, 0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
      4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0, 15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
    '{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10, 3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
      0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15, 13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
    '{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8, 13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
      13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7, 1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
    '{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15, 13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
      10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4, 3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
    '{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9, 14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
      4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14, 11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
    '{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11, 10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
      9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6, 4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
    '{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1, 13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
      1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2, 6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
    '{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7, 1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
      7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8, 2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11}};

  function automatic logic [63:0] perm_ip(input logic [63:0] v);
    logic [63:0] r;
    for (int i = 0; i < 64; i++) r[63-i] = v[64-int'(TabIp[i])];
    return r;
  endfunction

  function automatic logic [63:0] perm_fp(input logic [63:0] v);
    logic [63:0] r;
    for (int i = 0; i < 64; i++) r[63-i] = v[64-int'(TabFp[i])];
    return r;
  endfunction

  function automatic logic [55:0] perm_pc1(input logic [63:0] v);
    logic [55:0] r;
    for (int i = 0; i < 56; i++) r[55-i] = v[64-int'(TabPc1[i])];
    return r;
  endfunction

  function automatic logic [47:0] perm_pc2(input logic [55:0] v);
    logic [47:0] r;
    for (int i = 0; i < 48; i++) r[47-i] = v[56-int'(TabPc2[i])];
    return r;
  endfunction

  function automatic logic [31:0] feistel(input logic [31:0] r, input logic [47:0] k);
    logic [47:0] e;
    logic [31:0] s;
    logic [31:0] p;
    logic [5:0]  six;
    for (int i = 0; i < 48; i++) e[47-i] = r[32-int'(TabE[i])];
    e = e ^ k;
    for (int i = 0; i < 8; i++) begin
      six = e[47-6*i -: 6];
      s[31-4*i -: 4] = TabS[i][{six[5], six[0], six[4:1]}];
    end
    for (int i = 0; i < 32; i++) p[31-i] = s[32-int'(TabP[i])];
    return p;
  endfunction

endpackage

@@ rtl/des_block_encrypt_top.sv @@
// DES encryption top level: APB key register, initial permutation, a chain
// of sixteen round cells and the final permutation. Depends on des_pkg.
//
// Channel   Direction  Handshake            Payload
// input     in         start_i, busy_o      plain_block_i[63:0]
// result    out        done_o (one cycle)   cipher_block_o[63:0]
// config    in         APB write            cipher_key at address 0
//
// An item enters every cycle; busy_o is always low. An item passes through
// eighteen registers: one input register, sixteen round cells and one output
// register. Its done_o strobe rises when the item is in the output register,
// and cipher_block_o holds its result while done_o is high. Reset clears the key
// and all valid flags. The receiver cannot stall, so nothing holds the chain.
module des_block_encrypt_top import des_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [63:0] plain_block_i,
  output logic        done_o,
  output logic [63:0] cipher_block_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  localparam logic [3:0] AddrKey = 4'd0;

  logic [63:0] key_q;
  logic        in_valid_q;
  logic [63:0] in_blk_q;
  logic [55:0] cd0;
  logic [63:0] ip0;
  logic        out_valid_q;
  logic [63:0] out_blk_q;

  logic [Rounds:0]       v;
  logic [Rounds:0][31:0] l, r;
  logic [Rounds:0][27:0] c, d;

  assign pready = 1'b1;
  assign busy_o = 1'b0;
  assign prdata = (paddr == AddrKey) ? key_q : 64'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q       <= 64'd0;
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (psel && penable && pwrite && paddr == AddrKey) begin
        key_q <= pwdata;
      end
      in_valid_q  <= start_i;
      out_valid_q <= v[Rounds];
    end
  end

  always_ff @(posedge clk_i) begin
    in_blk_q  <= plain_block_i;
    out_blk_q <= perm_fp({r[Rounds], l[Rounds]});
  end

  assign cd0  = perm_pc1(key_q);
  assign ip0  = perm_ip(in_blk_q);
  assign v[0] = in_valid_q;
  assign l[0] = ip0[63:32];
  assign r[0] = ip0[31:0];
  assign c[0] = cd0[55:28];
  assign d[0] = cd0[27:0];

  for (genvar g = 0; g < Rounds; g++) begin : g_round
    des_round_cell #(.RotTwo(TabRotTwo[g])) u_cell (
      .clk_i, .rst_ni,
      .valid_i(v[g]), .l_i(l[g]), .r_i(r[g]), .c_i(c[g]), .d_i(d[g]),
      .valid_o(v[g+1]), .l_o(l[g+1]), .r_o(r[g+1]), .c_o(c[g+1]), .d_o(d[g+1])
    );
  end

  assign done_o = out_valid_q;
  assign cipher_block_o = out_blk_q;

endmodule

@@ rtl/des_round_cell.sv @@
// One DES round cell: rotates the key halves, runs the Feistel round and
// registers the result for the next cell. Depends on des_pkg.
module des_round_cell import des_pkg::*; #(
  parameter bit RotTwo = 1'b0
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  logic [31:0] l_i,
  input  logic [31:0] r_i,
  input  logic [27:0] c_i,
  input  logic [27:0] d_i,
  output logic        valid_o,
  output logic [31:0] l_o,
  output logic [31:0] r_o,
  output logic [27:0] c_o,
  output logic [27:0] d_o
);

  logic [27:0] c_d, d_d, c_q, d_q;
  logic [31:0] l_q, r_q, r_d;
  logic        valid_q;

  always_comb begin
    if (RotTwo) begin
      c_d = {c_i[25:0], c_i[27:26]};
      d_d = {d_i[25:0], d_i[27:26]};
    end else begin
      c_d = {c_i[26:0], c_i[27]};
      d_d = {d_i[26:0], d_i[27]};
    end
    r_d = l_i ^ feistel(r_i, perm_pc2({c_d, d_d}));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    l_q <= r_i;
    r_q <= r_d;
    c_q <= c_d;
    d_q <= d_d;
  end

  assign valid_o = valid_q;
  assign l_o = l_q;
  assign r_o = r_q;
  assign c_o = c_q;
  assign d_o = d_q;

endmodule
